// ----- rtl/size_class_slab_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Slab allocator assertion macros
// Clocked checks on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH

// property holds at every edge out of reset
`define SCSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// pre at one edge implies post at the next
`define SCSA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/scsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Slab allocator package
// Sizes, codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package scsa_pkg;

    localparam int SLOTS       = 256;
    localparam int SLOT_W      = 8;
    localparam int CLASSES     = 256;
    localparam int CLASS_W     = 8;
    localparam int MAX_BLOCKS  = 1024;
    localparam int BLK_W       = 10;
    localparam int CNT_W       = 11;
    localparam int FREE_W      = 9;
    localparam int HANDLE_W    = 18;
    localparam int STATUS_W    = 2;
    localparam int CHUNK_W     = 32;
    localparam int CHUNK_IX_W  = 5;
    localparam int CHUNKS      = SLOTS / CHUNK_W;
    localparam int CHUNK_SEL_W = 3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] RS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] RS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] RS_BAD_FREE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECIDE, ST_ALLOC, ST_SCAN, ST_FREE, ST_LINK, ST_RESP
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_RES_ZERO, OP_RES_EXH, OP_RES_BAD, OP_NEW,
        OP_RD_HEAD, OP_ALLOC, OP_SCAN, OP_FREE, OP_LINK, OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic size_zero;
        logic head_vld;
        logic blocks_full;
        logic handle_zero;
        logic handle_bad;
        logic slot_used;
        logic last_slot;
        logic was_full;
        logic scan_done;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [FREE_W-1:0]  free_cnt;
        logic [FREE_W-1:0]  low;
    } t_meta;

    typedef struct packed {
        logic             vld;
        logic [BLK_W-1:0] blk;
    } t_link;

endpackage

// ----- rtl/scsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences one word at a time through decide, update, scan and link steps.
// ----------------------------------------------------------------------------
`include "size_class_slab_allocator_assert.svh"

module scsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  scsa_pkg::t_stat i_stat,
    output scsa_pkg::t_cmd  o_cmd
);
    import scsa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_stat.kind == KIND_ALLOC) begin
                    if (i_stat.size_zero) begin
                        o_cmd.op = OP_RES_ZERO;
                        n_state  = ST_RESP;
                    end else if (i_stat.head_vld) begin
                        o_cmd.op = OP_RD_HEAD;
                        n_state  = ST_ALLOC;
                    end else if (i_stat.blocks_full) begin
                        o_cmd.op = OP_RES_EXH;
                        n_state  = ST_RESP;
                    end else begin
                        o_cmd.op = OP_NEW;
                        n_state  = ST_RESP;
                    end
                end else begin
                    if (i_stat.handle_zero) begin
                        o_cmd.op = OP_RES_ZERO;
                        n_state  = ST_RESP;
                    end else if (i_stat.handle_bad) begin
                        o_cmd.op = OP_RES_BAD;
                        n_state  = ST_RESP;
                    end else begin
                        n_state = ST_FREE;
                    end
                end
            end
            ST_ALLOC: begin
                o_cmd.op = OP_ALLOC;
                n_state  = i_stat.last_slot ? ST_RESP : ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_stat.scan_done) begin
                    n_state = ST_RESP;
                end
            end
            ST_FREE: begin
                if (!i_stat.slot_used) begin
                    o_cmd.op = OP_RES_BAD;
                    n_state  = ST_RESP;
                end else begin
                    o_cmd.op = OP_FREE;
                    n_state  = i_stat.was_full ? ST_LINK : ST_RESP;
                end
            end
            ST_LINK: begin
                o_cmd.op = OP_LINK;
                n_state  = ST_RESP;
            end
            ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `SCSA_ASSERT_NEXT(a_accept_decide, i_in_valid && o_in_ready, r_state == ST_DECIDE, "no decide")
    `SCSA_ASSERT(a_ready_idle, o_in_ready == (r_state == ST_IDLE), "ready outside idle")
    `SCSA_ASSERT(a_out_resp, (o_cmd.op == OP_OUT) |-> (r_state == ST_RESP), "output outside resp")

endmodule

// ----- rtl/scsa_dp.sv -----
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Block metadata, used-slot and link memories, class heads, free-slot scan
// and the output register.
// ----------------------------------------------------------------------------
`include "size_class_slab_allocator_assert.svh"

module scsa_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  scsa_pkg::t_cmd                    i_cmd,
    output scsa_pkg::t_stat                   o_stat,
    input  logic                              i_kind,
    input  logic [scsa_pkg::CLASS_W-1:0]      i_object_size,
    input  logic [scsa_pkg::HANDLE_W-1:0]     i_free_handle,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [scsa_pkg::HANDLE_W-1:0]     o_handle,
    output logic [scsa_pkg::STATUS_W-1:0]     o_status
);
    import scsa_pkg::*;

    logic [SLOTS-1:0] r_used_mem [MAX_BLOCKS];
    t_meta            r_meta_mem [MAX_BLOCKS];
    t_link            r_next_mem [MAX_BLOCKS];
    logic [BLK_W-1:0] r_head_mem [CLASSES];
    logic [CLASSES-1:0] r_head_vld;

    logic [SLOTS-1:0] r_used_q;
    t_meta            r_meta_q;
    t_link            r_next_q;
    logic [BLK_W-1:0] r_head_q;
    logic             r_head_vq;

    logic                r_kind;
    logic [CLASS_W-1:0]  r_size;
    logic [BLK_W-1:0]    r_blk;
    logic [SLOT_W-1:0]   r_slot;
    logic [CNT_W-1:0]    r_biu;

    logic [SLOTS-1:0]       r_scan_word;
    logic [CHUNK_SEL_W-1:0] r_chunk;
    logic [FREE_W-1:0]      r_newfree;

    logic [HANDLE_W-1:0] r_res_handle;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [STATUS_W-1:0] r_out_status;

    logic [BLK_W-1:0]    blk_rd_addr;
    logic                blk_re;
    logic [CLASS_W-1:0]  head_rd_addr;
    logic                head_re;

    logic                used_we, meta_we, next_we, head_we;
    logic [BLK_W-1:0]    used_wa, meta_wa, next_wa;
    logic [CLASS_W-1:0]  head_wa;
    logic [SLOTS-1:0]    used_wd;
    t_meta               meta_wd;
    t_link               next_wd;
    logic [BLK_W-1:0]    head_wd;
    logic                head_wv;

    logic [SLOT_W-1:0]   alloc_slot;
    logic [SLOTS-1:0]    slot_mask;
    logic [SLOTS-1:0]    free_mask;
    logic [FREE_W-1:0]   slot9;
    logic [FREE_W-1:0]   free_low;
    logic [CHUNK_W-1:0]  chunk_bits;
    logic                scan_found;
    logic [CHUNK_IX_W-1:0] scan_ix;
    logic [FREE_W-1:0]   scan_low;
    logic                blocks_full;
    logic                out_free;

    assign blocks_full = (r_biu == CNT_W'(MAX_BLOCKS));
    assign out_free    = !r_out_valid || i_out_ready;
    assign alloc_slot  = r_meta_q.low[FREE_W-1] ? '0 : r_meta_q.low[SLOT_W-1:0];
    assign slot_mask   = SLOTS'(1) << alloc_slot;
    assign free_mask   = SLOTS'(1) << r_slot;
    assign slot9       = {1'b0, r_slot};
    assign chunk_bits  = r_scan_word[r_chunk * CHUNK_W +: CHUNK_W];

    always_comb begin
        scan_found = 1'b0;
        scan_ix    = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            if (!chunk_bits[i]) begin
                scan_found = 1'b1;
                scan_ix    = CHUNK_IX_W'(i);
            end
        end
    end

    assign scan_low = scan_found ? {1'b0, r_chunk, scan_ix} : FREE_W'(SLOTS);

    always_comb begin
        if (r_meta_q.free_cnt == '0) begin
            free_low = slot9;
        end else if (slot9 < r_meta_q.low) begin
            free_low = slot9;
        end else begin
            free_low = r_meta_q.low;
        end
    end

    always_comb begin
        o_stat.kind        = r_kind;
        o_stat.size_zero   = (r_size == '0);
        o_stat.head_vld    = r_head_vq;
        o_stat.blocks_full = blocks_full;
        o_stat.handle_zero = (r_blk == '0) && (r_slot == '0);
        o_stat.handle_bad  = (r_blk == '0) || ({1'b0, r_blk} >= r_biu);
        o_stat.slot_used   = r_used_q[r_slot];
        o_stat.last_slot   = (r_meta_q.free_cnt == FREE_W'(1));
        o_stat.was_full    = (r_meta_q.free_cnt == '0);
        o_stat.scan_done   = scan_found || (r_chunk == CHUNK_SEL_W'(CHUNKS - 1));
        o_stat.out_free    = out_free;
    end

    // memory ports
    always_comb begin
        blk_rd_addr  = (i_cmd.op == OP_LOAD) ? i_free_handle[HANDLE_W-1:SLOT_W] : r_head_q;
        blk_re       = (i_cmd.op == OP_LOAD) || (i_cmd.op == OP_RD_HEAD);
        head_rd_addr = (i_cmd.op == OP_LOAD) ? i_object_size : r_meta_q.cls;
        head_re      = (i_cmd.op == OP_LOAD) || (i_cmd.op == OP_FREE);

        used_we = 1'b0; used_wa = r_blk; used_wd = r_used_q | slot_mask;
        meta_we = 1'b0; meta_wa = r_blk; meta_wd = r_meta_q;
        next_we = 1'b0; next_wa = r_blk; next_wd = '0;
        head_we = 1'b0; head_wa = r_size; head_wd = r_blk; head_wv = 1'b1;

        case (i_cmd.op)
            OP_NEW: begin
                used_we = 1'b1;
                used_wa = r_biu[BLK_W-1:0];
                used_wd = SLOTS'(1);
                meta_we = 1'b1;
                meta_wa = r_biu[BLK_W-1:0];
                meta_wd = '{cls: r_size, free_cnt: FREE_W'(SLOTS - 1), low: FREE_W'(1)};
                next_we = 1'b1;
                next_wa = r_biu[BLK_W-1:0];
                head_we = 1'b1;
                head_wd = r_biu[BLK_W-1:0];
            end
            OP_ALLOC: begin
                used_we = 1'b1;
                if (r_meta_q.free_cnt == FREE_W'(1)) begin
                    meta_we = 1'b1;
                    meta_wd = '{cls: r_meta_q.cls, free_cnt: '0, low: FREE_W'(SLOTS)};
                    head_we = 1'b1;
                    head_wd = r_next_q.blk;
                    head_wv = r_next_q.vld;
                end
            end
            OP_SCAN: begin
                if (o_stat.scan_done) begin
                    meta_we = 1'b1;
                    meta_wd = '{cls: r_meta_q.cls, free_cnt: r_newfree, low: scan_low};
                end
            end
            OP_FREE: begin
                used_we = 1'b1;
                used_wd = r_used_q & ~free_mask;
                meta_we = 1'b1;
                meta_wd = '{cls: r_meta_q.cls, free_cnt: r_meta_q.free_cnt + FREE_W'(1),
                            low: free_low};
            end
            OP_LINK: begin
                next_we = 1'b1;
                next_wd = '{vld: r_head_vq, blk: r_head_q};
                head_we = 1'b1;
                head_wa = r_meta_q.cls;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (used_we) begin
            r_used_mem[used_wa] <= used_wd;
        end
        if (blk_re) begin
            r_used_q <= r_used_mem[blk_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_wa] <= meta_wd;
        end
        if (blk_re) begin
            r_meta_q <= r_meta_mem[blk_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        if (blk_re) begin
            r_next_q <= r_next_mem[blk_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[head_wa] <= head_wd;
        end
        if (head_re) begin
            r_head_q <= r_head_mem[head_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= '0;
            r_head_vq  <= 1'b0;
        end else begin
            if (head_we) begin
                r_head_vld[head_wa] <= head_wv;
            end
            if (head_re) begin
                r_head_vq <= r_head_vld[head_rd_addr];
            end
        end
    end

    // word capture, scan and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_kind <= i_kind;
            r_size <= i_object_size;
            r_blk  <= i_free_handle[HANDLE_W-1:SLOT_W];
            r_slot <= i_free_handle[SLOT_W-1:0];
        end else if (i_cmd.op == OP_RD_HEAD) begin
            r_blk <= r_head_q;
        end
        case (i_cmd.op)
            OP_RES_ZERO, OP_FREE: begin
                r_res_handle <= '0;
                r_res_status <= RS_OK;
            end
            OP_RES_EXH: begin
                r_res_handle <= '0;
                r_res_status <= RS_EXHAUSTED;
            end
            OP_RES_BAD: begin
                r_res_handle <= '0;
                r_res_status <= RS_BAD_FREE;
            end
            OP_NEW: begin
                r_res_handle <= {r_biu[BLK_W-1:0], SLOT_W'(0)};
                r_res_status <= RS_OK;
            end
            OP_ALLOC: begin
                r_res_handle <= {r_blk, alloc_slot};
                r_res_status <= RS_OK;
                r_scan_word  <= r_used_q | slot_mask;
                r_chunk      <= alloc_slot[SLOT_W-1 -: CHUNK_SEL_W];
                r_newfree    <= r_meta_q.free_cnt - FREE_W'(1);
            end
            OP_SCAN: begin
                r_chunk <= r_chunk + CHUNK_SEL_W'(1);
            end
            default: begin
            end
        endcase
        if (i_cmd.op == OP_OUT) begin
            r_out_handle <= r_res_handle;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu       <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_NEW) begin
                r_biu <= r_biu + CNT_W'(1);
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_handle    = r_out_handle;
    assign o_status    = r_out_status;

    `SCSA_ASSERT(a_biu_range, (r_biu != '0) && (r_biu <= CNT_W'(MAX_BLOCKS)), "block count out of range")
    `SCSA_ASSERT(a_new_room, (i_cmd.op == OP_NEW) |-> !blocks_full, "new block with none left")
    `SCSA_ASSERT(a_scan_hit, ((i_cmd.op == OP_SCAN) && (r_chunk == CHUNK_SEL_W'(CHUNKS - 1))) |-> scan_found, "free slot scan ran off the block")

endmodule

// ----- rtl/size_class_slab_allocator.sv -----
// Flow: an allocate from a class head runs decide, allocate and, unless the block
// fills, a free-slot scan of 32 slots per cycle; a free runs decide, free and,
// for a block that was full, link. Throughput: one word at a time; a new word is
// taken in the cycle after the result is loaded into the output register, and the
// load waits while the output register is held.
// Reset: synchronous active low; clears class head valid bits, sets block count to one, no sweep.
// ----------------------------------------------------------------------------
// Size-class slab allocator
// Allocates and frees slots of per-class blocks kept on free-block lists.
// ----------------------------------------------------------------------------
module size_class_slab_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [scsa_pkg::CLASS_W-1:0]  i_object_size,
    input  logic [scsa_pkg::HANDLE_W-1:0] i_free_handle,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [scsa_pkg::HANDLE_W-1:0] o_handle,
    output logic [scsa_pkg::STATUS_W-1:0] o_status
);
    import scsa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    scsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    scsa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_kind),
        .i_object_size (i_object_size),
        .i_free_handle (i_free_handle),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_handle      (o_handle),
        .o_status      (o_status)
    );

endmodule

// ----- dv/tb_size_class_slab_allocator.sv -----
// ----------------------------------------------------------------------------
// Slab allocator testbench
// Drives allocate and free words through the valid/ready ports, predicts each
// result from its own model of the class lists, and compares field by field.
// ----------------------------------------------------------------------------
module tb_size_class_slab_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import scsa_pkg::*;

    localparam int NONE = -1;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_kind;
    logic [CLASS_W-1:0]  i_object_size;
    logic [HANDLE_W-1:0] i_free_handle;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [HANDLE_W-1:0] o_handle;
    logic [STATUS_W-1:0] o_status;

    size_class_slab_allocator uut (.*);

    typedef struct {
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
    } t_result;

    t_result expected_results[$];
    int      live_handles[$];
    int      errors;
    int      words_sent;
    int      results_seen;
    int      alloc_count;
    int      free_count;
    int      exhausted_count;
    int      bad_free_count;
    bit      hold_off;
    bit      rx_idle_en;

    // allocator mirror
    bit [SLOTS-1:0] used_map[MAX_BLOCKS];
    int             cls_of[MAX_BLOCKS];
    int             free_cnt[MAX_BLOCKS];
    int             low_slot[MAX_BLOCKS];
    int             prv[MAX_BLOCKS];
    int             nxt[MAX_BLOCKS];
    int             head_of[CLASSES];
    int             n_blocks;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void mirror_reset();
        for (int b = 0; b < MAX_BLOCKS; b++) begin
            used_map[b] = '0;
            cls_of[b] = 0;
            free_cnt[b] = 0;
            low_slot[b] = 0;
            prv[b] = NONE;
            nxt[b] = NONE;
        end
        for (int c = 0; c < CLASSES; c++) head_of[c] = NONE;
        free_cnt[0] = SLOTS;
        n_blocks = 1;
    endfunction

    function automatic void link_block(int b);
        int h;
        h = head_of[cls_of[b]];
        prv[b] = NONE;
        nxt[b] = h;
        if (h != NONE) prv[h] = b;
        head_of[cls_of[b]] = b;
    endfunction

    function automatic void unlink_block(int b);
        int p;
        int n;
        p = prv[b];
        n = nxt[b];
        prv[b] = NONE;
        nxt[b] = NONE;
        if (p != NONE) nxt[p] = n;
        if (n != NONE) prv[n] = p;
        if (head_of[cls_of[b]] == b) head_of[cls_of[b]] = n;
    endfunction

    function automatic t_result predict_allocation(logic kind, int size, int hnd);
        t_result r;
        int b;
        int s;
        int t;
        size = size & ((1 << CLASS_W) - 1);
        hnd = hnd & ((1 << HANDLE_W) - 1);
        r.handle = '0;
        r.status = RS_OK;
        if (kind == KIND_ALLOC) begin
            if (size == 0) return r;
            if (size >= CLASSES) begin
                r.status = RS_EXHAUSTED;
                return r;
            end
            if (head_of[size] == NONE) begin
                if (n_blocks >= MAX_BLOCKS) begin
                    r.status = RS_EXHAUSTED;
                    return r;
                end
                b = n_blocks++;
                cls_of[b] = size;
                free_cnt[b] = SLOTS;
                low_slot[b] = 0;
                used_map[b] = '0;
                link_block(b);
            end
            b = head_of[size];
            s = low_slot[b];
            if (s >= SLOTS) s = 0;
            used_map[b][s] = 1'b1;
            free_cnt[b]--;
            if (free_cnt[b] != 0) begin
                t = s + 1;
                while (t < SLOTS && used_map[b][t]) t++;
                low_slot[b] = t;
            end else begin
                low_slot[b] = SLOTS;
                unlink_block(b);
            end
            r.handle = HANDLE_W'(b * SLOTS + s);
        end else begin
            if (hnd == 0) return r;
            b = hnd / SLOTS;
            s = hnd % SLOTS;
            if (b == 0 || b >= n_blocks || !used_map[b][s]) begin
                r.status = RS_BAD_FREE;
                return r;
            end
            used_map[b][s] = 1'b0;
            if (free_cnt[b] == 0) begin
                link_block(b);
                low_slot[b] = s;
            end else if (s < low_slot[b]) begin
                low_slot[b] = s;
            end
            free_cnt[b]++;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic int idle_gap(bit allow_long);
        int n;
        n = ($urandom_range(0, 9) == 0 && allow_long) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        return n;
    endfunction

    task automatic send_word(logic kind, int size, int hnd, bit gaps = 1);
        t_result r;
        int n;
        n = gaps ? idle_gap(1) : 0;
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_object_size <= CLASS_W'(size);
        i_free_handle <= HANDLE_W'(hnd);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = predict_allocation(kind, size, hnd);
        expected_results.insert(expected_results.size(), r);
        words_sent++;
        if (kind == KIND_ALLOC) alloc_count++;
        else free_count++;
        if (r.status == RS_EXHAUSTED) exhausted_count++;
        if (r.status == RS_BAD_FREE) bad_free_count++;
        if (kind == KIND_ALLOC && r.status == RS_OK && r.handle != 0)
            live_handles.insert(live_handles.size(), int'(r.handle));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word, handle", o_handle, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_handle !== want.handle)
                    report_mismatch("handle", o_handle, want.handle);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
            end
        end
    end

    // receiver stalls
    initial begin
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    function automatic int take_live();
        int ix;
        ix = $urandom_range(0, live_handles.size() - 1);
        take_live = live_handles[ix];
        live_handles.delete(ix);
    endfunction

    task automatic test_special_cases();
        send_word(KIND_ALLOC, 0, 0);
        send_word(KIND_FREE, 0, 0);
        send_word(KIND_FREE, 0, 5);
        send_word(KIND_FREE, 0, SLOTS * 3);
        send_word(KIND_ALLOC, 1, 0);
        send_word(KIND_ALLOC, 255, '1);
        send_word(KIND_ALLOC, 1, 0);
        send_word(KIND_FREE, 255, SLOTS + 1);
        send_word(KIND_FREE, 0, SLOTS + 1);
        send_word(KIND_ALLOC, 1, 0);
        send_word(KIND_FREE, 0, (1 << HANDLE_W) - 1);
        send_word(KIND_FREE, 0, SLOTS + 200);
        send_word(KIND_ALLOC, 128, 0);
        send_word(KIND_FREE, 0, SLOTS);
        send_word(KIND_ALLOC, 1, 0);
        drain();
    endtask

    // fill one class block to full, free random live handles so a full block can relink
    task automatic test_full_block();
        for (int i = 0; i < SLOTS + 2; i++) send_word(KIND_ALLOC, 7, 0, i % 16 == 0);
        for (int i = 0; i < 6; i++) send_word(KIND_FREE, 0, take_live());
        for (int i = 0; i < 8; i++) send_word(KIND_ALLOC, 7, 0);
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++) send_word(KIND_ALLOC, $urandom_range(1, 20), 0, 0);
        drain();
    endtask

    task automatic test_random_mix(int count);
        int pick;
        rx_idle_en = 1'b1;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_word(KIND_ALLOC, $urandom_range(1, 40), $urandom);
            else if (pick < 80 && live_handles.size() != 0)
                send_word(KIND_FREE, $urandom, take_live());
            else if (pick < 90)
                send_word(KIND_FREE, $urandom, $urandom_range(0, (1 << HANDLE_W) - 1));
            else
                send_word(KIND_ALLOC, $urandom_range(0, 255), $urandom);
        end
        drain();
    endtask

    // one allocation in each of many classes, most opening a block of their own
    task automatic test_class_spread();
        rx_idle_en = 1'b0;
        for (int c = 100; c < 240; c++) send_word(KIND_ALLOC, c, 0, c % 8 == 0);
        for (int i = 0; i < 10; i++) send_word(KIND_ALLOC, $urandom_range(1, 255), 0);
        drain();
    endtask

    initial begin
        errors = 0;
        words_sent = 0;
        results_seen = 0;
        alloc_count = 0;
        free_count = 0;
        exhausted_count = 0;
        bad_free_count = 0;
        hold_off = 1'b0;
        rx_idle_en = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = KIND_ALLOC;
        i_object_size = '0;
        i_free_handle = '0;
        mirror_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_full_block();
        test_backpressure();
        test_random_mix(450);
        test_class_spread();

        repeat (30) @(posedge i_clk);
        $display("Covered %0d words: %0d allocations, %0d frees, %0d blocks created.",
                 words_sent, alloc_count, free_count, n_blocks);
        $display("Exhausted answers %0d, bad frees %0d, results checked %0d.",
                 exhausted_count, bad_free_count, results_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
